// ----- design/ild_pkg.sv -----
// Shared types and codes for the x86 instruction length decoder.
`timescale 1ns / 1ps

package ild_pkg;

   // decode phases
   localparam logic [2:0] PH_OP    = 3'd0;
   localparam logic [2:0] PH_OP2   = 3'd1;
   localparam logic [2:0] PH_MODRM = 3'd2;
   localparam logic [2:0] PH_SIB   = 3'd3;
   localparam logic [2:0] PH_DISP  = 3'd4;
   localparam logic [2:0] PH_IMM   = 3'd5;

   // pending special handling
   localparam logic [1:0] SP_NONE = 2'd0;
   localparam logic [1:0] SP_GRP3 = 2'd1;
   localparam logic [1:0] SP_INT  = 2'd2;

   // decode flag bits
   localparam logic [2:0] F_OPSZ  = 3'd0;
   localparam logic [2:0] F_ADSZ  = 3'd1;
   localparam logic [2:0] F_LOCK  = 3'd2;
   localparam logic [2:0] F_REP   = 3'd3;
   localparam logic [2:0] F_SEG   = 3'd4;
   localparam logic [2:0] F_TWO   = 3'd5;
   localparam logic [2:0] F_MODRM = 3'd6;
   localparam logic [2:0] F_SIB   = 3'd7;

   localparam logic [3:0] MAX_LEN = 4'd15;

   typedef struct packed {
      logic [2:0] phase;
      logic [7:0] flags;
      logic [3:0] count;
      logic [2:0] disp_left;
      logic [2:0] imm_left;
      logic [7:0] opcode;
      logic [7:0] opcode_two;
      logic [1:0] special;
   } state_type;

   typedef struct packed {
      logic [7:0] second_opcode;
      logic [7:0] first_opcode;
      logic [7:0] decode_flags;
      logic       is_error;
      logic [3:0] length;
   } result_type;

   localparam state_type STATE_RESET = '{
      phase: PH_OP, flags: 8'h00, count: 4'd0, disp_left: 3'd0,
      imm_left: 3'd0, opcode: 8'h00, opcode_two: 8'h00, special: SP_NONE
   };

endpackage

// ----- design/ild_decode.sv -----
// Per-byte decode step: next decoder state and the optional result.
`timescale 1ns / 1ps

module ild_decode (
   input  ild_pkg::state_type  state,
   input  logic [7:0]          code_byte,
   input  logic                restart,
   output ild_pkg::state_type  state_next,
   output logic                emit,
   output ild_pkg::result_type result
);

   always_comb begin
      ild_pkg::state_type s;
      logic [2:0] ds;
      logic [2:0] ms;
      logic [1:0] mod_f;
      logic [2:0] rm_f;
      logic       do_after;
      logic       do_settle;
      logic       done;
      logic       err;
      logic       pfx;
      logic [2:0] pbit;

      s         = restart ? ild_pkg::STATE_RESET : state;
      do_after  = 1'b0;
      do_settle = 1'b0;
      done      = 1'b0;
      err       = 1'b0;
      pfx       = 1'b0;
      pbit      = 3'd0;
      mod_f     = code_byte[7:6];
      rm_f      = code_byte[2:0];
      ds        = s.flags[ild_pkg::F_OPSZ] ? 3'd2 : 3'd4;
      ms        = s.flags[ild_pkg::F_ADSZ] ? 3'd2 : 3'd4;

      if (s.count >= ild_pkg::MAX_LEN) begin
         err = 1'b1;
      end else begin
         s.count = s.count + 4'd1;
         unique case (s.phase)
            ild_pkg::PH_OP: begin
               case (code_byte) inside
                  8'h0F: begin
                     s.opcode = code_byte;
                     s.flags[ild_pkg::F_TWO] = 1'b1;
                     s.phase = ild_pkg::PH_OP2;
                  end
                  8'h26, 8'h2E, 8'h36, 8'h3E, 8'h64, 8'h65: begin
                     pfx = 1'b1;
                     pbit = ild_pkg::F_SEG;
                  end
                  8'hF0: begin
                     pfx = 1'b1;
                     pbit = ild_pkg::F_LOCK;
                  end
                  8'hF2, 8'hF3: begin
                     pfx = 1'b1;
                     pbit = ild_pkg::F_REP;
                  end
                  8'h66: begin
                     pfx = 1'b1;
                     pbit = ild_pkg::F_OPSZ;
                  end
                  8'h67: begin
                     pfx = 1'b1;
                     pbit = ild_pkg::F_ADSZ;
                  end
                  8'hF1: err = 1'b1;
                  default: begin
                     s.opcode = code_byte;
                     do_after = 1'b1;
                     if (code_byte < 8'h40) begin
                        if (rm_f <= 3'd3) s.flags[ild_pkg::F_MODRM] = 1'b1;
                        else if (rm_f == 3'd4) s.imm_left = 3'd1;
                        else if (rm_f == 3'd5) s.imm_left = ds;
                     end else begin
                        case (code_byte) inside
                           [8'h70:8'h7F], [8'hB0:8'hB7]:
                              s.imm_left = 3'd1;
                           [8'hB8:8'hBF]:
                              s.imm_left = ds;
                           [8'h84:8'h8F], [8'hD8:8'hDF],
                           8'h62, 8'h63, 8'hC4, 8'hC5, [8'hD0:8'hD3], 8'hFE, 8'hFF:
                              s.flags[ild_pkg::F_MODRM] = 1'b1;
                           8'h6A, 8'hA8, 8'hD4, 8'hD5, [8'hE0:8'hE7], 8'hEB:
                              s.imm_left = 3'd1;
                           8'h6B, 8'h80, 8'h82, 8'h83, 8'hC0, 8'hC1, 8'hC6: begin
                              s.flags[ild_pkg::F_MODRM] = 1'b1;
                              s.imm_left = 3'd1;
                           end
                           8'h69, 8'h81, 8'hC7: begin
                              s.flags[ild_pkg::F_MODRM] = 1'b1;
                              s.imm_left = ds;
                           end
                           8'h9A, 8'hEA:
                              s.imm_left = ds + 3'd2;
                           [8'hA0:8'hA3]:
                              s.disp_left = ms;
                           8'h68, 8'hA9, 8'hE8, 8'hE9:
                              s.imm_left = ds;
                           8'hC2, 8'hCA:
                              s.imm_left = 3'd2;
                           8'hC8:
                              s.imm_left = 3'd3;
                           8'hCD: begin
                              s.imm_left = 3'd1;
                              s.special = ild_pkg::SP_INT;
                           end
                           8'hF6, 8'hF7: begin
                              s.flags[ild_pkg::F_MODRM] = 1'b1;
                              s.special = ild_pkg::SP_GRP3;
                           end
                           default: ;
                        endcase
                     end
                  end
               endcase
               if (pfx) begin
                  if (s.flags[pbit]) err = 1'b1;
                  else s.flags[pbit] = 1'b1;
               end
            end
            ild_pkg::PH_OP2: begin
               s.opcode_two = code_byte;
               do_after = 1'b1;
               case (code_byte) inside
                  [8'h00:8'h03], [8'h90:8'h9F], [8'hB0:8'hB7], [8'hBB:8'hBF],
                  8'hA3, 8'hA5, 8'hAB, 8'hAD, 8'hAF, 8'hC0, 8'hC1, 8'h12, 8'h13:
                     s.flags[ild_pkg::F_MODRM] = 1'b1;
                  [8'h80:8'h8F]:
                     s.imm_left = ds;
                  [8'h08:8'h0B], [8'hC8:8'hCF],
                  8'h06, 8'hA0, 8'hA1, 8'hA2, 8'hA8, 8'hA9, 8'hAA: ;
                  default: begin
                     do_after = 1'b0;
                     err = 1'b1;
                  end
               endcase
            end
            ild_pkg::PH_MODRM: begin
               do_settle = 1'b1;
               if (s.special == ild_pkg::SP_GRP3) begin
                  s.special = ild_pkg::SP_NONE;
                  if (code_byte[5:3] == 3'd0)
                     s.imm_left = s.opcode[0] ? ds : 3'd1;
               end
               if (mod_f != 2'd3) begin
                  if (mod_f == 2'd1) s.disp_left = 3'd1;
                  if (mod_f == 2'd2) s.disp_left = ms;
                  if (s.flags[ild_pkg::F_ADSZ]) begin
                     if (mod_f == 2'd0 && rm_f == 3'd6) s.disp_left = 3'd2;
                  end else if (rm_f == 3'd4) begin
                     s.flags[ild_pkg::F_SIB] = 1'b1;
                     s.phase = ild_pkg::PH_SIB;
                     do_settle = 1'b0;
                  end else if (rm_f == 3'd5 && mod_f == 2'd0) begin
                     s.disp_left = 3'd4;
                  end
               end
            end
            ild_pkg::PH_SIB: begin
               // no displacement yet means mod was 0
               if (rm_f == 3'd5 && s.disp_left == 3'd0) s.disp_left = 3'd4;
               do_settle = 1'b1;
            end
            ild_pkg::PH_DISP: begin
               if (s.disp_left != 3'd0) s.disp_left = s.disp_left - 3'd1;
               if (s.disp_left == 3'd0) do_settle = 1'b1;
            end
            ild_pkg::PH_IMM: begin
               if (s.special == ild_pkg::SP_INT) begin
                  s.special = ild_pkg::SP_NONE;
                  if (code_byte == 8'h20) s.imm_left = s.imm_left + 3'd4;
               end
               if (s.imm_left != 3'd0) s.imm_left = s.imm_left - 3'd1;
               if (s.imm_left == 3'd0) done = 1'b1;
            end
            default: err = 1'b1;
         endcase
      end

      if (do_after) begin
         if (s.flags[ild_pkg::F_MODRM]) s.phase = ild_pkg::PH_MODRM;
         else do_settle = 1'b1;
      end
      if (do_settle) begin
         if (s.disp_left != 3'd0) s.phase = ild_pkg::PH_DISP;
         else if (s.imm_left != 3'd0) s.phase = ild_pkg::PH_IMM;
         else done = 1'b1;
      end

      emit = err || done;
      if (err) begin
         result = '{second_opcode: 8'h00, first_opcode: 8'h00, decode_flags: 8'h00,
                    is_error: 1'b1, length: 4'd0};
      end else begin
         result = '{second_opcode: s.opcode_two, first_opcode: s.opcode,
                    decode_flags: s.flags, is_error: 1'b0, length: s.count};
      end
      state_next = emit ? ild_pkg::STATE_RESET : s;
   end

endmodule

// ----- design/x86_instruction_length_decoder.sv -----
// Top level of the 32-bit x86 instruction length decoder.
`timescale 1ns / 1ps
//
// The req channel carries the code stream, one byte per transfer: tdata is
// the byte, tuser[0] is restart, which drops any partial instruction so the
// byte starts a new one. The rsp channel carries one transfer per finished
// instruction or per error: tdata holds length, decode flags and the opcode
// bytes, tuser[0] is the error flag (length and the rest are 0 on error).
// A byte goes into an input register, is decoded against the decoder state
// and its result lands in the output register, which drives rsp_tvalid.
// One byte is taken every cycle unless the receiver stalls with a result
// held; throughput is set by the single decode stage. Bytes that finish no
// instruction produce nothing on rsp.
// Reset clears the decoder state and both valid flags. When the receiver
// stalls with a result held, the input register still accepts one more
// byte; further bytes wait until the held result is transferred.

module x86_instruction_length_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] code_byte
   input  logic [0:0]  req_tuser,   // [0] restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [3:0] length, [11:4] decode_flags,
                                    // [19:12] first_opcode, [27:20] second_opcode
   output logic [0:0]  rsp_tuser    // [0] is_error
);

   logic                in_valid_ff;
   logic [7:0]          in_byte_ff;
   logic                in_restart_ff;
   ild_pkg::state_type  state_ff;
   ild_pkg::state_type  state_in;
   logic                rsp_valid_ff;
   ild_pkg::result_type rsp_data_ff;
   ild_pkg::result_type result;
   logic                emit;
   logic                out_free;
   logic                advance;

   ild_decode u_decode (
      .state      (state_ff),
      .code_byte  (in_byte_ff),
      .restart    (in_restart_ff),
      .state_next (state_in),
      .emit       (emit),
      .result     (result)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= ild_pkg::STATE_RESET;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            state_ff <= state_in;
         end
         // load a new result or drop the one just transferred
         if (advance && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff    <= req_tdata;
         in_restart_ff <= req_tuser[0];
      end
      if (advance && emit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.is_error;
   assign rsp_tdata  = {4'd0, rsp_data_ff.second_opcode, rsp_data_ff.first_opcode,
                        rsp_data_ff.decode_flags, rsp_data_ff.length};

endmodule

// ----- dv/x86_instruction_length_decoder_tb.sv -----
// Self-checking testbench for the x86 instruction length decoder.
`timescale 1ns / 1ps

module x86_instruction_length_decoder_tb;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DIRECTED_COUNT = 32;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] code_byte
   logic [0:0]  req_tuser = 1'b0;    // [0] restart
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;           // [3:0] length, [11:4] decode_flags,
                                     // [19:12] first_opcode, [27:20] second_opcode
   logic [0:0]  rsp_tuser;           // [0] is_error

   x86_instruction_length_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   // decoder state as the testbench sees it
   logic [2:0] dec_phase;
   logic [7:0] dec_flags;
   logic [3:0] dec_count;
   logic [2:0] dec_disp;
   logic [2:0] dec_imm;
   logic [7:0] dec_op;
   logic [7:0] dec_op2;
   logic [1:0] dec_special;

   ild_pkg::result_type awaited_decodes [$];
   ild_pkg::result_type oldest_decode;
   int         mismatch_count = 0;
   int         quiet_cycles = 0;
   logic       idle_on = 1'b1;

   logic [7:0] prefix_bytes [11] = '{8'h26, 8'h2E, 8'h36, 8'h3E, 8'h64, 8'h65,
                                     8'hF0, 8'hF2, 8'hF3, 8'h66, 8'h67};
   logic [7:0] special_ops [20] = '{8'hF6, 8'hF7, 8'hCD, 8'h9A, 8'hEA, 8'hA0, 8'hA3,
                                    8'hC8, 8'hC2, 8'h81, 8'h69, 8'hC7, 8'h05, 8'hB8,
                                    8'h68, 8'hE8, 8'hF1, 8'h8B, 8'h00, 8'h6B};
   logic [7:0] two_byte_ops [28] = '{8'h00, 8'h03, 8'h06, 8'h08, 8'h12, 8'h13, 8'h80,
                                     8'h8F, 8'h90, 8'h9F, 8'hA0, 8'hA2, 8'hA3, 8'hA5,
                                     8'hA8, 8'hAA, 8'hAF, 8'hB0, 8'hB7, 8'hBB, 8'hBF,
                                     8'hC0, 8'hC1, 8'hC8, 8'hCF, 8'hA4, 8'hAC, 8'hBA};
   // {restart, code_byte}
   logic [8:0] directed_bytes [DIRECTED_COUNT] = '{
      9'h0F1,                                     // invalid opcode
      9'h066, 9'h066,                             // repeated operand-size prefix
      9'h00F, 9'h0A4,                             // unknown two-byte opcode
      9'h0F6, 9'h0C0, 9'h0FF,                     // group 3, reg 0: imm8
      9'h0F7, 9'h0D8,                             // group 3, reg 3: no imm
      9'h0CD, 9'h020, 9'h011, 9'h022, 9'h033, 9'h044,  // int 20h + 4 bytes
      9'h067, 9'h08B, 9'h006, 9'h034, 9'h012,     // 16-bit addr, disp16
      9'h000, 9'h004, 9'h0FD, 9'h000, 9'h0FF, 9'h000, 9'h0FF,  // SIB base 5
      9'h005, 9'h011,                             // partial, dropped by restart
      9'h1FF, 9'h0C0
   };

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got 0x%0h want 0x%0h at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   task automatic clear_decoder();
      dec_phase   = ild_pkg::PH_OP;
      dec_flags   = 8'h00;
      dec_count   = 4'd0;
      dec_disp    = 3'd0;
      dec_imm     = 3'd0;
      dec_op      = 8'h00;
      dec_op2     = 8'h00;
      dec_special = ild_pkg::SP_NONE;
   endtask

   task automatic push_instruction();
      ild_pkg::result_type r;
      r.length        = dec_count;
      r.is_error      = 1'b0;
      r.decode_flags  = dec_flags;
      r.first_opcode  = dec_op;
      r.second_opcode = dec_op2;
      awaited_decodes.push_back(r);
      clear_decoder();
   endtask

   task automatic push_error();
      ild_pkg::result_type r;
      r = '0;
      r.is_error = 1'b1;
      awaited_decodes.push_back(r);
      clear_decoder();
   endtask

   task automatic settle_operands();
      if (dec_disp != 3'd0) dec_phase = ild_pkg::PH_DISP;
      else if (dec_imm != 3'd0) dec_phase = ild_pkg::PH_IMM;
      else push_instruction();
   endtask

   task automatic after_opcode();
      if (dec_flags[ild_pkg::F_MODRM]) dec_phase = ild_pkg::PH_MODRM;
      else settle_operands();
   endtask

   task automatic take_prefix(input logic [2:0] bit_index);
      if (dec_flags[bit_index]) push_error();
      else dec_flags[bit_index] = 1'b1;
   endtask

   task automatic decode_opcode(input logic [7:0] b);
      logic [2:0] ds;
      logic [2:0] ms;
      ds = dec_flags[ild_pkg::F_OPSZ] ? 3'd2 : 3'd4;
      ms = dec_flags[ild_pkg::F_ADSZ] ? 3'd2 : 3'd4;
      case (b)
         8'h0F: begin
            dec_op = b;
            dec_flags[ild_pkg::F_TWO] = 1'b1;
            dec_phase = ild_pkg::PH_OP2;
         end
         8'h26, 8'h2E, 8'h36, 8'h3E, 8'h64, 8'h65: take_prefix(ild_pkg::F_SEG);
         8'hF0: take_prefix(ild_pkg::F_LOCK);
         8'hF2, 8'hF3: take_prefix(ild_pkg::F_REP);
         8'h66: take_prefix(ild_pkg::F_OPSZ);
         8'h67: take_prefix(ild_pkg::F_ADSZ);
         8'hF1: push_error();
         default: begin
            dec_op = b;
            if (b < 8'h40) begin
               if (b[2:0] <= 3'd3) dec_flags[ild_pkg::F_MODRM] = 1'b1;
               else if (b[2:0] == 3'd4) dec_imm = 3'd1;
               else if (b[2:0] == 3'd5) dec_imm = ds;
            end else if ((b >= 8'h70 && b <= 8'h7F) || (b >= 8'hB0 && b <= 8'hB7)) begin
               dec_imm = 3'd1;
            end else if (b >= 8'hB8) begin
               if (b <= 8'hBF) dec_imm = ds;
               else if (b >= 8'hD8 && b <= 8'hDF) dec_flags[ild_pkg::F_MODRM] = 1'b1;
               else begin
                  case (b)
                     8'hC4, 8'hC5, 8'hD0, 8'hD1, 8'hD2, 8'hD3, 8'hFE, 8'hFF:
                        dec_flags[ild_pkg::F_MODRM] = 1'b1;
                     8'hD4, 8'hD5, 8'hE4, 8'hE5, 8'hE6, 8'hE7, 8'hEB, 8'hE0, 8'hE1,
                     8'hE2, 8'hE3:
                        dec_imm = 3'd1;
                     8'hC0, 8'hC1, 8'hC6: begin
                        dec_flags[ild_pkg::F_MODRM] = 1'b1;
                        dec_imm = 3'd1;
                     end
                     8'hC7: begin
                        dec_flags[ild_pkg::F_MODRM] = 1'b1;
                        dec_imm = ds;
                     end
                     8'hEA: dec_imm = ds + 3'd2;
                     8'hE8, 8'hE9: dec_imm = ds;
                     8'hC2, 8'hCA: dec_imm = 3'd2;
                     8'hC8: dec_imm = 3'd3;
                     8'hCD: begin
                        dec_imm = 3'd1;
                        dec_special = ild_pkg::SP_INT;
                     end
                     8'hF6, 8'hF7: begin
                        dec_flags[ild_pkg::F_MODRM] = 1'b1;
                        dec_special = ild_pkg::SP_GRP3;
                     end
                     default: ;
                  endcase
               end
            end else if (b >= 8'h84 && b <= 8'h8F) begin
               dec_flags[ild_pkg::F_MODRM] = 1'b1;
            end else begin
               case (b)
                  8'h62, 8'h63: dec_flags[ild_pkg::F_MODRM] = 1'b1;
                  8'h6A, 8'hA8: dec_imm = 3'd1;
                  8'h6B, 8'h80, 8'h82, 8'h83: begin
                     dec_flags[ild_pkg::F_MODRM] = 1'b1;
                     dec_imm = 3'd1;
                  end
                  8'h69, 8'h81: begin
                     dec_flags[ild_pkg::F_MODRM] = 1'b1;
                     dec_imm = ds;
                  end
                  8'h9A: dec_imm = ds + 3'd2;
                  8'hA0, 8'hA1, 8'hA2, 8'hA3: dec_disp = ms;
                  8'h68, 8'hA9: dec_imm = ds;
                  default: ;
               endcase
            end
            after_opcode();
         end
      endcase
   endtask

   task automatic decode_second(input logic [7:0] b);
      logic [2:0] ds;
      ds = dec_flags[ild_pkg::F_OPSZ] ? 3'd2 : 3'd4;
      dec_op2 = b;
      if (b <= 8'h03 || (b >= 8'h90 && b <= 8'h9F) || (b >= 8'hB0 && b <= 8'hB7) ||
          (b >= 8'hBB && b <= 8'hBF)) begin
         dec_flags[ild_pkg::F_MODRM] = 1'b1;
         after_opcode();
      end else if (b >= 8'h80 && b <= 8'h8F) begin
         dec_imm = ds;
         after_opcode();
      end else if ((b >= 8'h08 && b <= 8'h0B) || (b >= 8'hC8 && b <= 8'hCF)) begin
         after_opcode();
      end else begin
         case (b)
            8'hA3, 8'hA5, 8'hAB, 8'hAD, 8'hAF, 8'hC0, 8'hC1, 8'h12, 8'h13: begin
               dec_flags[ild_pkg::F_MODRM] = 1'b1;
               after_opcode();
            end
            8'h06, 8'hA0, 8'hA1, 8'hA2, 8'hA8, 8'hA9, 8'hAA: after_opcode();
            default: push_error();
         endcase
      end
   endtask

   task automatic decode_modrm(input logic [7:0] b);
      logic [2:0] ms;
      logic       to_sib;
      ms = dec_flags[ild_pkg::F_ADSZ] ? 3'd2 : 3'd4;
      to_sib = 1'b0;
      if (dec_special == ild_pkg::SP_GRP3) begin
         dec_special = ild_pkg::SP_NONE;
         if (b[5:3] == 3'd0)
            dec_imm = dec_op[0] ? (dec_flags[ild_pkg::F_OPSZ] ? 3'd2 : 3'd4) : 3'd1;
      end
      if (b[7:6] != 2'b11) begin
         if (b[7:6] == 2'b01) dec_disp = 3'd1;
         if (b[7:6] == 2'b10) dec_disp = ms;
         if (ms == 3'd2) begin
            if (b[7:6] == 2'b00 && b[2:0] == 3'd6) dec_disp = 3'd2;
         end else if (b[2:0] == 3'd4) begin
            dec_flags[ild_pkg::F_SIB] = 1'b1;
            dec_phase = ild_pkg::PH_SIB;
            to_sib = 1'b1;
         end else if (b[2:0] == 3'd5 && b[7:6] == 2'b00) begin
            dec_disp = 3'd4;
         end
      end
      if (!to_sib) settle_operands();
   endtask

   task automatic track_instruction_byte(input logic [7:0] b, input logic restart);
      if (restart) clear_decoder();
      if (dec_count >= ild_pkg::MAX_LEN) begin
         push_error();
      end else begin
         dec_count = dec_count + 4'd1;
         case (dec_phase)
            ild_pkg::PH_OP:    decode_opcode(b);
            ild_pkg::PH_OP2:   decode_second(b);
            ild_pkg::PH_MODRM: decode_modrm(b);
            ild_pkg::PH_SIB: begin
               // no displacement yet means mod was 0
               if (b[2:0] == 3'd5 && dec_disp == 3'd0) dec_disp = 3'd4;
               settle_operands();
            end
            ild_pkg::PH_DISP: begin
               if (dec_disp != 3'd0) dec_disp = dec_disp - 3'd1;
               if (dec_disp == 3'd0) settle_operands();
            end
            ild_pkg::PH_IMM: begin
               if (dec_special == ild_pkg::SP_INT) begin
                  dec_special = ild_pkg::SP_NONE;
                  if (b == 8'h20) dec_imm = dec_imm + 3'd4;
               end
               if (dec_imm != 3'd0) dec_imm = dec_imm - 3'd1;
               if (dec_imm == 3'd0) push_instruction();
            end
            default: push_error();
         endcase
      end
   endtask

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_code_byte(input logic [7:0] b, input logic restart);
      if (idle_on) begin
         while ($urandom_range(99) < 12) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= restart;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      track_instruction_byte(b, restart);
   endtask

   // Bias the next byte toward what the decoder is waiting for.
   task automatic pick_code_byte(output logic [7:0] b, output logic restart);
      logic [31:0] rnd;
      int          roll;
      rnd = $urandom;
      roll = $urandom_range(99);
      b = rnd[7:0];
      restart = 1'b0;
      if (roll < 8) begin
         restart = rnd[8];
      end else begin
         roll = $urandom_range(99);
         case (dec_phase)
            ild_pkg::PH_OP: begin
               if (roll < 25) b = prefix_bytes[$urandom_range(10)];
               else if (roll < 35) b = 8'h0F;
               else if (roll < 60) b = special_ops[$urandom_range(19)];
            end
            ild_pkg::PH_OP2: if (roll < 75) b = two_byte_ops[$urandom_range(27)];
            ild_pkg::PH_MODRM: begin
               if (roll < 40) b[5:3] = 3'd0;
               if (rnd[11]) b[2:0] = (rnd[9:8] == 2'd0) ? 3'd6 : {2'b10, rnd[10]};
            end
            ild_pkg::PH_SIB: if (roll < 40) b[2:0] = 3'd5;
            ild_pkg::PH_IMM: if (dec_special == ild_pkg::SP_INT && roll < 50) b = 8'h20;
            default: ;
         endcase
      end
   endtask

   task automatic test_directed();
      for (int i = 0; i < DIRECTED_COUNT; i++)
         send_code_byte(directed_bytes[i][7:0], directed_bytes[i][8]);
   endtask

   task automatic test_random_stream(input int count);
      logic [7:0] b;
      logic       restart;
      for (int i = 0; i < count; i++) begin
         pick_code_byte(b, restart);
         send_code_byte(b, restart);
      end
   endtask

   // Stop sending after each burst until every decode has come back.
   task automatic test_drain_pauses(input int bursts);
      for (int i = 0; i < bursts; i++) begin
         test_random_stream($urandom_range(40, 10));
         req_tvalid <= 1'b0;
         while (awaited_decodes.size() != 0) @(posedge clock);
         @(negedge clock);
      end
   endtask

   always @(negedge clock)
      rsp_tready <= !(idle_on && $urandom_range(99) < 12);

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_decodes.size() == 0) begin
            report_mismatch("result with none awaited", rsp_tdata, 0);
         end else begin
            oldest_decode = awaited_decodes.pop_front();
            if (rsp_tdata[3:0] !== oldest_decode.length)
               report_mismatch("length", rsp_tdata[3:0], oldest_decode.length);
            if (rsp_tuser[0] !== oldest_decode.is_error)
               report_mismatch("is_error", rsp_tuser[0], oldest_decode.is_error);
            if (rsp_tdata[11:4] !== oldest_decode.decode_flags)
               report_mismatch("decode_flags", rsp_tdata[11:4], oldest_decode.decode_flags);
            if (rsp_tdata[19:12] !== oldest_decode.first_opcode)
               report_mismatch("first_opcode", rsp_tdata[19:12], oldest_decode.first_opcode);
            if (rsp_tdata[27:20] !== oldest_decode.second_opcode)
               report_mismatch("second_opcode", rsp_tdata[27:20],
                               oldest_decode.second_opcode);
         end
      end
   end

   // Abort when neither channel has moved for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      clear_decoder();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_stream(900);
      idle_on = 1'b0;
      test_random_stream(400);
      idle_on = 1'b1;
      test_drain_pauses(15);
      test_random_stream(300);
      req_tvalid <= 1'b0;
      while (awaited_decodes.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && awaited_decodes.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
